// ----- rtl/gkf_pkg.sv -----
// ----------------------------------------------------------------------------
// gkf_pkg: shared types and constants of the 3x3 gradient kernel filter
// Field widths, register indexes, the kernel weight table and the
// kernel evaluation with saturation to the 8-bit output range.
// ----------------------------------------------------------------------------
package gkf_pkg;

  localparam int PIX_W      = 8;
  localparam int KTYPE_W    = 3;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int HEIGHT_MAX = 4096;
  localparam int OUT_ROW_W  = 12;
  localparam int IMG_W_RST  = 1024;
  localparam int IMG_H_RST  = 1024;
  localparam int NUM_KERN   = 8;
  localparam int NUM_TAPS   = 9;
  localparam int SUM_W      = 14;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_TYPE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  // Kernel codes as the kernel_type register holds them
  typedef enum logic [KTYPE_W-1:0] {
    KERN_PREWITT_X   = 3'd0,
    KERN_PREWITT_Y   = 3'd1,
    KERN_KIRSCH_Y    = 3'd2,
    KERN_KIRSCH_X    = 3'd3,
    KERN_KIRSCH_DIAG = 3'd4,
    KERN_DIFF_X      = 3'd5,
    KERN_DIFF_Y      = 3'd6,
    KERN_UNUSED      = 3'd7
  } kernel_t;

  typedef logic signed [3:0] weight_t;

  // 3x3 pixels, tap index row * 3 + column, row 0 at the top
  typedef logic [NUM_TAPS-1:0][PIX_W-1:0] taps_t;

  // Weights by row (top to bottom) then column (left to right)
  localparam weight_t KERN_TAB [NUM_KERN][NUM_TAPS] = '{
    '{-4'sd1,  4'sd0,  4'sd1, -4'sd1,  4'sd0,  4'sd1, -4'sd1,  4'sd0,  4'sd1},
    '{-4'sd1, -4'sd1, -4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd1,  4'sd1},
    '{ 4'sd3,  4'sd3,  4'sd3,  4'sd3,  4'sd0,  4'sd3, -4'sd5, -4'sd5, -4'sd5},
    '{-4'sd5,  4'sd3,  4'sd3, -4'sd5,  4'sd0,  4'sd3, -4'sd5,  4'sd3,  4'sd3},
    '{ 4'sd3,  4'sd3,  4'sd3, -4'sd5,  4'sd0,  4'sd3, -4'sd5, -4'sd5,  4'sd3},
    '{ 4'sd0,  4'sd0,  4'sd0, -4'sd1,  4'sd0,  4'sd1,  4'sd0,  4'sd0,  4'sd0},
    '{ 4'sd0, -4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd0},
    '{ 4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd0}
  };

  // Correlate the window with the selected kernel and clamp to 0..255
  function automatic logic [PIX_W-1:0] kern_apply(input logic [KTYPE_W-1:0] kt,
                                                  input taps_t px);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] term;
    logic [PIX_W-1:0]        res;
    sum = '0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      term = SUM_W'(KERN_TAB[kt][i]) * SUM_W'(signed'({1'b0, px[i]}));
      sum  = sum + term;
    end
    if (sum < 0) begin
      res = '0;
    end else if (sum > SUM_W'(255)) begin
      res = '1;
    end else begin
      res = sum[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/gkf_if.sv -----
// ----------------------------------------------------------------------------
// gkf_if: channel interfaces of the 3x3 gradient kernel filter
// Pixel input stream, gradient output stream and configuration write port,
// each a valid/ready channel with source and sink modports.
// ----------------------------------------------------------------------------
interface gkf_pix_if import gkf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output func, output pixel, input ready);
  modport sink   (input valid, input func, input pixel, output ready);
endinterface

interface gkf_grad_if import gkf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] gradient;
  logic             last;

  modport source (output valid, output gradient, output last, input ready);
  modport sink   (input valid, input gradient, input last, output ready);
endinterface

interface gkf_cfg_if import gkf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/gradient_kernel_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// gradient_kernel_filter_3x3: 3x3 gradient convolution on a pixel stream
// Correlates a raster-ordered 8-bit frame with a selectable gradient kernel
// (Prewitt, Kirsch compass, simple difference) with replicated borders.
// ----------------------------------------------------------------------------
// Usage:
//   cfg      - register writes: 0 kernel_type, 1 image_width, 2 image_height.
//              Always ready. Writing width or height restarts the frame.
//              Write only while the filter is idle.
//   pix_in   - one pixel per transaction in raster order (func 0), or a drain
//              tick (func 1). Drain ticks inside the frame are dropped; after
//              the last pixel, image_width + 1 drain ticks flush the tail.
//   grad_out - one gradient per transaction, last marks the frame's final one.
// Throughput is one transaction per cycle while grad_out does not stall. The
// two line buffers share one RAM (16 bits wide, MAX_WIDTH deep), read on
// acceptance and written back the following cycle, with forwarding when the
// same column is read and written. A result passes the RAM read register,
// then kernel evaluation into a three-entry output queue, to grad_out;
// output pixel (r, c) is produced by input (r + 1, c + 1), so the frame lags
// by one row and one pixel. When grad_out stalls, the queue absorbs the items
// in flight and pix_in.ready drops once the queue cannot take another one.
// Reset clears positions, window and queue and loads the register defaults.
// ----------------------------------------------------------------------------
module gradient_kernel_filter_3x3 import gkf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  gkf_cfg_if.sink     cfg,
  gkf_pix_if.sink     pix_in,
  gkf_grad_if.source  grad_out
);

  localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int W_RST     = (IMG_W_RST > MAX_WIDTH) ? MAX_WIDTH : IMG_W_RST;
  localparam int LINE_W    = 2 * PIX_W;
  localparam int QDEPTH    = 3;
  localparam int QPW       = 2;

  typedef logic [2:0][PIX_W-1:0] col_t;   // rows top, middle, bottom

  typedef struct packed {
    logic [CW-1:0]    addr;
    logic [PIX_W-1:0] pixel;
    logic             emit;
    logic             last;
    logic             shift;
    logic             wr;
    logic             top_rep;
    logic             bot_rep;
    logic             lsel;
    logic             rsel;
  } s1_ctl_t;

  // Configuration registers
  logic [KTYPE_W-1:0] kernel_type;
  logic [WW-1:0]      eff_w;
  logic [IMG_H_W-1:0] eff_h;

  // Position counters
  logic [CW-1:0]        in_column;
  logic [IMG_H_W-1:0]   in_row;
  logic [CW-1:0]        out_column;
  logic [OUT_ROW_W-1:0] out_row;

  // Stage 1 and forwarding
  logic             s1_valid;
  s1_ctl_t          s1;
  s1_ctl_t          s1_next;
  logic             s1_fwd;
  logic [PIX_W-1:0] fwd_above;
  logic [PIX_W-1:0] fwd_cur;

  // Window of three columns, index 2 newest
  col_t win [3];

  // Output queue
  logic [PIX_W:0]   q_mem [QDEPTH];
  logic [QPW-1:0]   q_wptr;
  logic [QPW-1:0]   q_rptr;
  logic [QPW-1:0]   q_cnt;

  logic              cfg_acc;
  logic              acc;
  logic              in_frame;
  logic              drop;
  logic              emit;
  logic              col_last;
  logic              ocol_last;
  logic              orow_last;
  logic              frame_last;
  logic              advance;
  logic [IMG_W_W-1:0] wv;
  logic [IMG_H_W-1:0] hv;
  logic [WW-1:0]      wv_eff;
  logic [IMG_H_W-1:0] hv_eff;

  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] line;
  logic [PIX_W-1:0]  line_above;
  logic [PIX_W-1:0]  line_cur;
  col_t              new_col;
  col_t              lc;
  col_t              rc;
  taps_t             px;
  logic [PIX_W-1:0]  grad;
  logic              push;
  logic              pop;

  function automatic logic [QPW-1:0] q_inc(input logic [QPW-1:0] p);
    return (p == QPW'(QDEPTH - 1)) ? '0 : p + QPW'(1);
  endfunction

  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid && cfg.ready;
  assign acc       = pix_in.valid && pix_in.ready;

  // Clamp geometry writes into the supported range
  assign wv = cfg.data[IMG_W_W-1:0];
  assign hv = cfg.data[IMG_H_W-1:0];

  always_comb begin
    if (wv == '0) begin
      wv_eff = WW'(1);
    end else if (32'(wv) > MAX_WIDTH) begin
      wv_eff = WW'(MAX_WIDTH);
    end else begin
      wv_eff = WW'(wv);
    end
    if (hv == '0) begin
      hv_eff = IMG_H_W'(1);
    end else if (32'(hv) > HEIGHT_MAX) begin
      hv_eff = IMG_H_W'(HEIGHT_MAX);
    end else begin
      hv_eff = hv;
    end
  end

  // Classify the incoming transaction from the position counters
  assign in_frame   = in_row < eff_h;
  assign drop       = in_frame && pix_in.func;
  assign emit       = (in_row >= IMG_H_W'(2)) ||
                      ((in_row == IMG_H_W'(1)) && (in_column != '0));
  assign col_last   = (WW'(in_column) + WW'(1)) >= eff_w;
  assign ocol_last  = (WW'(out_column) + WW'(1)) >= eff_w;
  assign orow_last  = ({1'b0, out_row} + IMG_H_W'(1)) >= eff_h;
  assign frame_last = emit && orow_last && ocol_last;
  assign advance    = acc && !drop;

  always_comb begin
    s1_next.addr    = in_column;
    s1_next.pixel   = pix_in.pixel;
    s1_next.emit    = emit;
    s1_next.last    = frame_last;
    s1_next.shift   = in_row <= eff_h;
    s1_next.wr      = in_frame;
    s1_next.top_rep = in_row <= IMG_H_W'(1);
    s1_next.bot_rep = !in_frame;
    s1_next.lsel    = out_column != '0;
    s1_next.rsel    = (in_column != '0) && !ocol_last;
  end

  // Configuration registers and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_type <= '0;
      eff_w       <= WW'(W_RST);
      eff_h       <= IMG_H_W'(IMG_H_RST);
      in_column   <= '0;
      in_row      <= '0;
      out_column  <= '0;
      out_row     <= '0;
    end else if (cfg_acc) begin
      unique case (cfg.index)
        REG_KERNEL_TYPE: begin
          kernel_type <= cfg.data[KTYPE_W-1:0];
        end
        REG_IMAGE_WIDTH: begin
          eff_w      <= wv_eff;
          in_column  <= '0;
          in_row     <= '0;
          out_column <= '0;
          out_row    <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          eff_h      <= hv_eff;
          in_column  <= '0;
          in_row     <= '0;
          out_column <= '0;
          out_row    <= '0;
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      if (frame_last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (col_last) begin
          in_column <= '0;
          in_row    <= in_row + IMG_H_W'(1);
        end else begin
          in_column <= in_column + CW'(1);
        end
        if (emit) begin
          if (ocol_last) begin
            out_column <= '0;
            out_row    <= out_row + OUT_ROW_W'(1);
          end else begin
            out_column <= out_column + CW'(1);
          end
        end
      end
    end
  end

  // Line buffers: {line above, current line} per column
  gkf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid && s1.wr),
    .waddr (s1.addr),
    .wdata ({line_cur, s1.pixel}),
    .re    (advance),
    .raddr (in_column),
    .rdata (ram_rdata)
  );

  // Advance stage 1; forward the write-back when the same column is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1        <= s1_next;
      s1_fwd    <= s1_valid && s1.wr && (s1.addr == in_column);
      fwd_above <= line_cur;
      fwd_cur   <= s1.pixel;
    end
  end

  // Build the new window column with vertical replication
  assign line       = s1_fwd ? {fwd_above, fwd_cur} : ram_rdata;
  assign line_above = line[LINE_W-1:PIX_W];
  assign line_cur   = line[PIX_W-1:0];

  always_comb begin
    new_col[0] = s1.top_rep ? line_cur : line_above;
    new_col[1] = line_cur;
    new_col[2] = s1.bot_rep ? line_cur : s1.pixel;
  end

  // Select left and right columns, replicating at the row ends
  always_comb begin
    lc = s1.lsel ? win[1] : win[2];
    rc = s1.rsel ? new_col : win[2];
    for (int r = 0; r < 3; r++) begin
      px[r*3]     = lc[r];
      px[r*3 + 1] = win[2][r];
      px[r*3 + 2] = rc[r];
    end
  end

  assign grad = kern_apply(kernel_type, px);

  // Shift the window
  always_ff @(posedge clk) begin
    if (rst) begin
      win[0] <= '0;
      win[1] <= '0;
      win[2] <= '0;
    end else if (s1_valid && s1.shift) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= new_col;
    end
  end

  // Output queue
  assign push = s1_valid && s1.emit;
  assign pop  = grad_out.valid && grad_out.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wptr] <= {s1.last, grad};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wptr <= '0;
      q_rptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (push) begin
        q_wptr <= q_inc(q_wptr);
      end
      if (pop) begin
        q_rptr <= q_inc(q_rptr);
      end
      priority if (push && !pop) begin
        q_cnt <= q_cnt + QPW'(1);
      end else if (pop && !push) begin
        q_cnt <= q_cnt - QPW'(1);
      end else begin
        q_cnt <= q_cnt;
      end
    end
  end

  assign grad_out.valid    = q_cnt != '0;
  assign grad_out.gradient = q_mem[q_rptr][PIX_W-1:0];
  assign grad_out.last     = q_mem[q_rptr][PIX_W];

  // Hold input while the queue could not take the items in flight
  assign pix_in.ready = ({1'b0, q_cnt} + {2'b00, s1_valid}) <= (QPW + 1)'(QDEPTH - 1);

endmodule

// ----- rtl/gkf_ram.sv -----
// ----------------------------------------------------------------------------
// gkf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module gkf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/gkf_gradient_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkf_gradient_check: gradient stream predictor and comparator
// Watches the configuration, pixel and gradient channels of the 3x3 gradient
// kernel filter. It keeps its own line buffers, window and frame positions,
// works out the gradient that each accepted pixel transaction releases and
// compares each accepted gradient transaction with the oldest expected one.
// ----------------------------------------------------------------------------
module gkf_gradient_check import gkf_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic clk,
  input  logic rst,
  gkf_cfg_if   cfg,
  gkf_pix_if   pix,
  gkf_grad_if  grad,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic [PIX_W-1:0] gradient;
    logic             last;
  } grad_item_t;

  // Weights by row (top to bottom) then column (left to right), one row per kernel code
  localparam int WEIGHT [8][9] = '{
    '{-1,  0,  1, -1,  0,  1, -1,  0,  1},
    '{-1, -1, -1,  0,  0,  0,  1,  1,  1},
    '{ 3,  3,  3,  3,  0,  3, -5, -5, -5},
    '{-5,  3,  3, -5,  0,  3, -5,  3,  3},
    '{ 3,  3,  3, -5,  0,  3, -5, -5,  3},
    '{ 0,  0,  0, -1,  0,  1,  0,  0,  0},
    '{ 0, -1,  0,  0,  0,  0,  0,  1,  0},
    '{ 0,  0,  0,  0,  0,  0,  0,  0,  0}
  };

  kernel_t              kernel;
  logic [IMG_W_W-1:0]   width_reg;
  logic [IMG_H_W-1:0]   height_reg;
  logic [PIX_W-1:0]     row_above [MAX_WIDTH];
  logic [PIX_W-1:0]     row_now [MAX_WIDTH];
  logic [PIX_W-1:0]     win [9];          // win[column * 3 + row], column 2 newest
  int unsigned          in_col, in_row, out_col, out_row;
  grad_item_t           grad_expected [$];
  grad_item_t           head;
  int                   mismatches = 0;

  task automatic restart_positions();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endtask

  // Correlate the window around one centre column, replicating at the row ends
  function automatic logic [PIX_W-1:0] gradient_at(int unsigned centre, int unsigned w);
    int unsigned col_sel [3];
    int          acc;
    col_sel[0] = (out_col == 0) ? centre : centre - 1;
    col_sel[1] = centre;
    col_sel[2] = (out_col + 1 >= w) ? centre : centre + 1;
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc += WEIGHT[int'(kernel)][r * 3 + c] * int'(win[col_sel[c] * 3 + r]);
      end
    end
    if (acc < 0) return '0;
    if (acc > 255) return '1;
    return PIX_W'(acc);
  endfunction

  // Advance the filter by one pixel transaction and queue the gradient it releases
  task automatic predict_gradient(input logic drain, input logic [PIX_W-1:0] px);
    int unsigned      w, h, r, c;
    logic [PIX_W-1:0] p, top, mid, bot, g;
    logic             emit;
    grad_item_t       item;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg);
    r = in_row;
    c = in_col;
    p = px;
    g = '0;
    // drop drain ticks inside the frame; past it every item flushes
    if (r < h) begin
      if (drain) return;
    end else begin
      p = '0;
    end
    emit = (r >= 2) || (r == 1 && c >= 1);
    if (c == 0 && emit) g = gradient_at(2, w);
    if (r <= h) begin
      mid = row_now[c];
      top = (r <= 1) ? mid : row_above[c];
      bot = (r >= h) ? mid : p;
      for (int i = 0; i < 6; i++) win[i] = win[i + 3];
      win[6] = top;
      win[7] = mid;
      win[8] = bot;
      if (r < h) begin
        row_above[c] = mid;
        row_now[c]   = p;
      end
    end
    if (c >= 1 && emit) g = gradient_at(1, w);
    if (emit) begin
      item.gradient = g;
      item.last     = (out_row + 1 >= h) && (out_col + 1 >= w);
      grad_expected.push_back(item);
      if (item.last) begin
        restart_positions();
        return;
      end
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    in_col = c;
    in_row = r;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kernel     = KERN_PREWITT_X;
      width_reg  = IMG_W_W'(IMG_W_RST);
      height_reg = IMG_H_W'(IMG_H_RST);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above[i] = '0;
        row_now[i]   = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      restart_positions();
      grad_expected.delete();
    end else begin
      // compare the gradient transaction with the oldest expectation
      if (grad.valid && grad.ready) begin
        if (grad_expected.size() == 0) begin
          $error("unexpected gradient transaction: gradient %0d last %0d",
                 grad.gradient, grad.last);
          mismatches++;
        end else begin
          head = grad_expected.pop_front();
          if (grad.gradient !== head.gradient) begin
            $error("gradient mismatch: expected %0d, actual %0d", head.gradient,
                   grad.gradient);
            mismatches++;
          end
          if (grad.last !== head.last) begin
            $error("last mismatch: expected %0d, actual %0d", head.last, grad.last);
            mismatches++;
          end
        end
      end
      // track register writes; geometry writes abort the frame
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_KERNEL_TYPE: begin
            kernel = kernel_t'(cfg.data[KTYPE_W-1:0]);
          end
          REG_IMAGE_WIDTH: begin
            width_reg = cfg.data[IMG_W_W-1:0];
            restart_positions();
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = cfg.data[IMG_H_W-1:0];
            restart_positions();
          end
          default: begin
          end
        endcase
      end
      if (pix.valid && pix.ready) predict_gradient(pix.func, pix.pixel);
    end
    outstanding <= grad_expected.size();
    fail_count  <= mismatches;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the 3x3 gradient kernel filter
// Drives register writes and pixel frames, directed ones first (extreme
// geometries, unused codes, drain ticks, surplus pixels, aborted frames),
// then random frames under four idling phases, with long output hold-offs.
// Prediction and comparison live in gkf_gradient_check.
// ----------------------------------------------------------------------------
module tb import gkf_pkg::*; ();

  localparam int MAX_WIDTH       = 1024;
  localparam int CLK_PERIOD      = 12;
  localparam int QUIET_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 120;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int LIMIT_CYCLES    = 600000;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk;
  logic rst;
  int   idle_pct;
  int   stall_pct;
  logic hold_token;
  logic hold_seen;
  int   hold_left;
  int   fail_count;
  int   outstanding;

  gkf_cfg_if  cfg_if ();
  gkf_pix_if  pix_if ();
  gkf_grad_if grad_if ();

  gradient_kernel_filter_3x3 #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_if),
    .pix_in   (pix_if),
    .grad_out (grad_if)
  );

  gkf_gradient_check #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_gradient_check (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_if),
    .pix         (pix_if),
    .grad        (grad_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("gradient_kernel_filter_3x3 verification failed");
    $finish;
  end

  // Gradient receiver: random stalls, plus a long hold-off on each token toggle
  initial begin
    grad_if.ready <= 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        grad_if.ready <= 1'b0;
      end else begin
        grad_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Bias towards the extremes so that the sums saturate both ways
  function automatic logic [PIX_W-1:0] pick_pixel();
    unique case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one pixel transaction after a random gap; hold until accepted
  task automatic send_item(input logic func, input logic [PIX_W-1:0] px);
    cfg_if.valid <= 1'b0;
    while ($urandom_range(0, 99) < idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.func  <= func;
    pix_if.pixel <= px;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  // Stop sending and wait until every expected gradient has come out
  task automatic quiet();
    pix_if.valid <= 1'b0;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // Kernel code in the low bits, junk above them
  task automatic set_kernel(input int code);
    logic [CFG_DATA_W-1:0] value;
    value = CFG_DATA_W'($urandom_range(0, 8191));
    value[KTYPE_W-1:0] = KTYPE_W'(code);
    write_reg(REG_KERNEL_TYPE, value);
  endtask

  // Write both geometry registers and return the size that applies
  task automatic set_geometry(input int width_val, input int height_val,
                              output int cols, output int rows);
    write_reg(REG_IMAGE_WIDTH, {2'($urandom_range(0, 3)), IMG_W_W'(width_val)});
    write_reg(REG_IMAGE_HEIGHT, IMG_H_W'(height_val));
    cols = (width_val == 0) ? 1 : ((width_val > MAX_WIDTH) ? MAX_WIDTH : width_val);
    rows = (height_val == 0) ? 1 : ((height_val > HEIGHT_MAX) ? HEIGHT_MAX : height_val);
  endtask

  // Send a frame with stray drains inside it; cut < 0 sends it whole with its
  // flush tail (part drains, part surplus pixels), else stop after cut pixels
  task automatic stream_frame(input int cols, input int rows, input int cut,
                              output int items);
    int total;
    total = (cut >= 0) ? cut : cols * rows;
    items = total;
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(FUNC_DRAIN, PIX_W'($urandom_range(0, 255)));
      send_item(FUNC_PIXEL, pick_pixel());
    end
    if (cut < 0) begin
      for (int i = 0; i <= cols; i++) begin
        send_item(($urandom_range(0, 3) == 0) ? FUNC_PIXEL : FUNC_DRAIN,
                  PIX_W'($urandom_range(0, 255)));
      end
      items += cols + 1;
    end
  endtask

  int   cols;
  int   rows;
  int   items;
  int   sent;
  int   frame_count;
  int   cut;
  logic restart_frame;

  initial begin
    rst          <= 1'b1;
    idle_pct     <= 0;
    stall_pct    <= 0;
    hold_token   <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.func  <= FUNC_PIXEL;
    pix_if.pixel <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_KERNEL_TYPE;
    cfg_if.data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Small frame with a leading drain tick, against a long output hold-off
    write_reg(REG_SPARE, '1);
    set_kernel(KERN_PREWITT_X);
    set_geometry(3, 3, cols, rows);
    hold_token <= ~hold_token;
    send_item(FUNC_DRAIN, '1);
    stream_frame(cols, rows, -1, items);

    // Unused kernel code on a zero-sized frame, which counts as one pixel
    quiet();
    set_kernel(KERN_UNUSED);
    set_geometry(0, 0, cols, rows);
    stream_frame(cols, rows, -1, items);

    // Abort a frame part way, then a fresh one
    quiet();
    set_kernel(KERN_KIRSCH_Y);
    set_geometry(2, 3, cols, rows);
    stream_frame(cols, rows, 3, items);
    quiet();
    set_geometry(2, 2, cols, rows);
    stream_frame(cols, rows, -1, items);

    // Oversized width counts as the full line length, oversized height as the
    // row limit; cut both frames short part way
    quiet();
    set_kernel(KERN_KIRSCH_X);
    set_geometry(2047, 2, cols, rows);
    stream_frame(cols, rows, cols + 6, items);
    quiet();
    set_kernel(KERN_KIRSCH_DIAG);
    set_geometry(1, 8191, cols, rows);
    stream_frame(cols, rows, 40, items);

    // Random frames under each idling phase
    restart_frame = 1'b1;
    frame_count   = 0;
    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin idle_pct <= 0;  stall_pct <= 0;  end
        1: begin idle_pct <= 68; stall_pct <= 0;  end
        2: begin idle_pct <= 0;  stall_pct <= 68; end
        default: begin idle_pct <= 14; stall_pct <= 14; end
      endcase
      hold_token <= ~hold_token;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (restart_frame || frame_count < 8 || $urandom_range(0, 3) == 0) begin
          quiet();
          set_kernel((frame_count < 8) ? frame_count : $urandom_range(0, 7));
          if ($urandom_range(0, 9) == 0) begin
            set_geometry($urandom_range(9, 48), $urandom_range(1, 6), cols, rows);
          end else begin
            set_geometry($urandom_range(1, 8), $urandom_range(1, 6), cols, rows);
          end
        end
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cols * rows - 1) : -1;
        stream_frame(cols, rows, cut, items);
        restart_frame = (cut >= 0);
        sent += items;
        frame_count++;
        // Occasionally let the pipeline run dry between frames
        if ($urandom_range(0, 7) == 0) quiet();
      end
    end

    quiet();
    if (fail_count == 0) begin
      $display("gradient_kernel_filter_3x3 verification clean");
    end else begin
      $display("gradient_kernel_filter_3x3 verification failed");
    end
    $finish;
  end

endmodule

// ----- gradient_kernel_filter_3x3.f -----
rtl/gkf_pkg.sv
rtl/gkf_if.sv
rtl/gkf_ram.sv
rtl/gradient_kernel_filter_3x3.sv
tb/gkf_gradient_check.sv
tb/tb.sv
